// ----- rtl/macd_pkg.sv -----
package macd_pkg;

  // Fixed field widths
  localparam int PRICE_W = 32;
  localparam int AVG_W   = 48;
  localparam int DIFF_W  = AVG_W + 1;
  localparam int SUM_W   = AVG_W + 4;
  localparam int CASH_W  = 56;
  localparam int CSUM_W  = CASH_W + 2;
  localparam int POS_W   = 11;
  localparam int LIMIT_W = 10;
  localparam int PM_W    = POS_W + PRICE_W + 1;
  localparam int STEP_W  = 4;

  // Averaging divisors (period + 1): alpha = 2 / (period + 1)
  localparam int LONG_DIV  = 27;
  localparam int SHORT_DIV = 13;
  localparam int SIG_DIV   = 10;
  localparam int ALPHA_NUM = 2;

  // Register map
  localparam int  ADDR_W           = 3;
  localparam logic REG_MAX_POSITION = 1'b0;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    SEL_LONG  = 2'd0,
    SEL_SHORT = 2'd1,
    SEL_SIG   = 2'd2
  } avg_sel_t;

  typedef enum logic [1:0] {
    JC_NONE        = 2'd0,
    JC_ALWAYS      = 2'd1,
    JC_NOT_STARTED = 2'd2
  } jump_t;

  // Program steps
  localparam logic [STEP_W-1:0] ST_MUL_LONG  = 4'd0;
  localparam logic [STEP_W-1:0] ST_WB_LONG   = 4'd1;
  localparam logic [STEP_W-1:0] ST_WB_SHORT  = 4'd2;
  localparam logic [STEP_W-1:0] ST_MACD      = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_SIG   = 4'd4;
  localparam logic [STEP_W-1:0] ST_WB_SIG    = 4'd5;
  localparam logic [STEP_W-1:0] ST_TRADE     = 4'd6;
  localparam logic [STEP_W-1:0] ST_PROF_MUL  = 4'd7;
  localparam logic [STEP_W-1:0] ST_DONE      = 4'd8;
  localparam logic [STEP_W-1:0] ST_INIT      = 4'd9;

  typedef struct packed {
    logic              mul_en;
    avg_sel_t          mul_sel;
    logic              wb_en;
    avg_sel_t          wb_sel;
    logic              macd_en;
    logic              init_en;
    logic              trade_en;
    logic              pmul_en;
    logic              done;
    jump_t             jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '0;
    cw.mul_sel = SEL_LONG;
    cw.wb_sel  = SEL_LONG;
    cw.jmp     = JC_NONE;
    unique case (step)
      ST_MUL_LONG: begin
        cw.mul_en  = 1'b1;
        cw.mul_sel = SEL_LONG;
        cw.jmp     = JC_NOT_STARTED;
        cw.target  = ST_INIT;
      end
      ST_WB_LONG: begin
        cw.wb_en   = 1'b1;
        cw.wb_sel  = SEL_LONG;
        cw.mul_en  = 1'b1;
        cw.mul_sel = SEL_SHORT;
      end
      ST_WB_SHORT: begin
        cw.wb_en  = 1'b1;
        cw.wb_sel = SEL_SHORT;
      end
      ST_MACD:     cw.macd_en = 1'b1;
      ST_MUL_SIG: begin
        cw.mul_en  = 1'b1;
        cw.mul_sel = SEL_SIG;
      end
      ST_WB_SIG: begin
        cw.wb_en  = 1'b1;
        cw.wb_sel = SEL_SIG;
      end
      ST_TRADE:    cw.trade_en = 1'b1;
      ST_PROF_MUL: cw.pmul_en  = 1'b1;
      ST_DONE:     cw.done     = 1'b1;
      ST_INIT: begin
        cw.init_en = 1'b1;
        cw.jmp     = JC_ALWAYS;
        cw.target  = ST_TRADE;
      end
      default:     cw.done = 1'b1;
    endcase
    return cw;
  endfunction

  // Saturate to the signed average range
  function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [SUM_W-1:0] v);
    logic ovf;
    ovf = (v[SUM_W-1:AVG_W-1] != '0) && (v[SUM_W-1:AVG_W-1] != '1);
    if (!ovf) begin
      return v[AVG_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(AVG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(AVG_W-1){1'b1}}};
    end
  endfunction

  // Saturate to the signed cash range
  function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CSUM_W-1:0] v);
    logic ovf;
    ovf = (v[CSUM_W-1:CASH_W-1] != '0) && (v[CSUM_W-1:CASH_W-1] != '1);
    if (!ovf) begin
      return v[CASH_W-1:0];
    end else if (v[CSUM_W-1]) begin
      return {1'b1, {(CASH_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CASH_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/macd_crossover_position_tracker.sv -----
// MACD 12/26/9 crossover position tracker.
// Input channel (in_valid / in_stall): one closing price per transaction, unsigned
// fixed point, plus in_is_last marking the final price of a run. Output channel
// (out_valid / out_stall): one result per input transaction carrying the trade action,
// the position and cash after the trade, the final profit (zero unless last) and last.
// Configuration goes over the APB-style port: max_position at byte address 0.
// A microcoded sequencer steps one shared EMA multiplier and a small position
// multiplier through a ten-word program ROM, one control word per cycle except
// while held on its output step. A running item passes the steps EMA long, short,
// MACD, signal, trade, profit product and output load before out_valid; the first
// item of a run seeds the averages in place of the EMA, MACD and signal steps.
// The block takes one item at a time: in_stall is high from acceptance until the
// result is loaded; the three EMA multiply/writeback pairs are serialized on the
// shared multiplier.
// The result register frees the sequencer: a new item is accepted while an earlier
// result still waits. When out_stall holds the result and the next item is done,
// the sequencer holds on its output step until the register empties.
// Reset (synchronous, rst_n low) clears the sequencer, the valid flag, the
// started flag and sets max_position to 1; the next item then begins a new run.
module macd_crossover_position_tracker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transaction
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [macd_pkg::PRICE_W-1:0]         in_close_price,
  input  logic                                 in_is_last,
  // result transaction
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_action,
  output logic signed [macd_pkg::POS_W-1:0]    out_position,
  output logic signed [macd_pkg::CASH_W-1:0]   out_cash,
  output logic signed [macd_pkg::CASH_W-1:0]   out_final_profit,
  output logic                                 out_last,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [macd_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int AVG_W  = macd_pkg::AVG_W;
  localparam int DIFF_W = macd_pkg::DIFF_W;
  localparam int SUM_W  = macd_pkg::SUM_W;
  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int DELTA_W = PROD_W - FRAC_BITS;
  localparam int CSUM_W = macd_pkg::CSUM_W;

  // alpha = round(2/(d+1) * 2^FRAC_BITS) with d+1 the divisor
  localparam logic [ALPHA_W-1:0] ALPHA_LONG  = ALPHA_W'(
    ((2 * macd_pkg::ALPHA_NUM << FRAC_BITS) + macd_pkg::LONG_DIV) / (2 * macd_pkg::LONG_DIV));
  localparam logic [ALPHA_W-1:0] ALPHA_SHORT = ALPHA_W'(
    ((2 * macd_pkg::ALPHA_NUM << FRAC_BITS) + macd_pkg::SHORT_DIV) / (2 * macd_pkg::SHORT_DIV));
  localparam logic [ALPHA_W-1:0] ALPHA_SIG   = ALPHA_W'(
    ((2 * macd_pkg::ALPHA_NUM << FRAC_BITS) + macd_pkg::SIG_DIV) / (2 * macd_pkg::SIG_DIV));

  // control state
  logic                                busy_r;
  logic [macd_pkg::STEP_W-1:0]         step_r;
  logic                                started_r;
  logic                                out_valid_r;
  logic [macd_pkg::LIMIT_W-1:0]        max_pos_r;

  // datapath registers
  logic [macd_pkg::PRICE_W-1:0]        price_r;
  logic                                last_r;
  logic signed [AVG_W-1:0]             long_r;
  logic signed [AVG_W-1:0]             short_r;
  logic signed [AVG_W-1:0]             sig_r;
  logic signed [AVG_W-1:0]             macd_r;
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [macd_pkg::POS_W-1:0]   held_r;
  logic signed [macd_pkg::CASH_W-1:0]  cash_r;
  logic signed [macd_pkg::PM_W-1:0]    pm_r;
  macd_pkg::action_t                   action_r;

  // result register
  logic [1:0]                          out_action_r;
  logic signed [macd_pkg::POS_W-1:0]   out_position_r;
  logic signed [macd_pkg::CASH_W-1:0]  out_cash_r;
  logic signed [macd_pkg::CASH_W-1:0]  out_profit_r;
  logic                                out_last_r;

  macd_pkg::ucode_t                    cw;
  logic                                in_acc;
  logic                                cfg_wr;
  logic                                adv;
  logic                                take_jump;

  logic signed [AVG_W-1:0]             mul_avg;
  logic signed [AVG_W-1:0]             mul_tgt;
  logic [ALPHA_W-1:0]                  mul_alpha;
  logic signed [DIFF_W-1:0]            diff;
  logic signed [AVG_W-1:0]             wb_avg;
  logic signed [DELTA_W-1:0]           delta;
  logic signed [AVG_W-1:0]             wb_val;
  logic signed [AVG_W-1:0]             macd_val;

  logic signed [macd_pkg::POS_W-1:0]   limit_pos;
  logic signed [macd_pkg::POS_W-1:0]   limit_neg;
  logic                                do_buy;
  logic                                do_sell;
  logic signed [CSUM_W-1:0]            cash_sum;
  logic signed [CSUM_W-1:0]            prof_sum;

  assign cw     = macd_pkg::ucode_rom(step_r);
  assign in_acc = in_valid && !in_stall;
  assign in_stall = busy_r;

  // Hold on the output step while the previous result is still stalled.
  assign adv       = busy_r && !(cw.done && out_valid_r && out_stall);
  assign take_jump = (cw.jmp == macd_pkg::JC_ALWAYS) ||
                     ((cw.jmp == macd_pkg::JC_NOT_STARTED) && !started_r);

  // Configuration port: single register, zero-wait.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[macd_pkg::ADDR_W-1] == macd_pkg::REG_MAX_POSITION);
  assign prdata = (paddr[macd_pkg::ADDR_W-1] == macd_pkg::REG_MAX_POSITION) ?
                  {{(32 - macd_pkg::LIMIT_W){1'b0}}, max_pos_r} : '0;

  // Operand select for the shared EMA multiplier.
  always_comb begin
    unique case (cw.mul_sel)
      macd_pkg::SEL_SHORT: begin
        mul_avg   = short_r;
        mul_tgt   = $signed({{(AVG_W - macd_pkg::PRICE_W){1'b0}}, price_r});
        mul_alpha = ALPHA_SHORT;
      end
      macd_pkg::SEL_SIG: begin
        mul_avg   = sig_r;
        mul_tgt   = macd_r;
        mul_alpha = ALPHA_SIG;
      end
      default: begin
        mul_avg   = long_r;
        mul_tgt   = $signed({{(AVG_W - macd_pkg::PRICE_W){1'b0}}, price_r});
        mul_alpha = ALPHA_LONG;
      end
    endcase
  end

  assign diff = DIFF_W'(mul_tgt) - DIFF_W'(mul_avg);

  // Writeback: avg + floor(product / 2^FRAC_BITS), saturated.
  always_comb begin
    unique case (cw.wb_sel)
      macd_pkg::SEL_SHORT: wb_avg = short_r;
      macd_pkg::SEL_SIG:   wb_avg = sig_r;
      default:             wb_avg = long_r;
    endcase
  end

  assign delta  = prod_r[PROD_W-1:FRAC_BITS];
  assign wb_val = macd_pkg::sat_avg(SUM_W'(wb_avg) + SUM_W'(delta));

  assign macd_val = macd_pkg::sat_avg(SUM_W'(short_r) - SUM_W'(long_r));

  // Trade decision against the position limit.
  assign limit_pos = $signed({1'b0, max_pos_r});
  assign limit_neg = -limit_pos;
  assign do_buy    = (macd_r > sig_r) && (held_r < limit_pos);
  assign do_sell   = (macd_r < sig_r) && (held_r > limit_neg);

  always_comb begin
    if (do_buy) begin
      cash_sum = CSUM_W'(cash_r) - $signed({{(CSUM_W - macd_pkg::PRICE_W){1'b0}}, price_r});
    end else begin
      cash_sum = CSUM_W'(cash_r) + $signed({{(CSUM_W - macd_pkg::PRICE_W){1'b0}}, price_r});
    end
  end

  assign prof_sum = CSUM_W'(cash_r) + CSUM_W'(pm_r);

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= macd_pkg::ST_MUL_LONG;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      max_pos_r   <= macd_pkg::LIMIT_W'(1);
    end else begin
      if (cfg_wr) begin
        max_pos_r <= pwdata[macd_pkg::LIMIT_W-1:0];
      end
      // Load a new result, else drop valid once the receiver takes it.
      if (adv && cw.done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        busy_r <= 1'b1;
        step_r <= macd_pkg::ST_MUL_LONG;
      end else if (adv) begin
        if (cw.done) begin
          busy_r      <= 1'b0;
          step_r      <= macd_pkg::ST_MUL_LONG;
          if (last_r) begin
            started_r <= 1'b0;
          end
        end else if (take_jump) begin
          step_r <= cw.target;
        end else begin
          step_r <= step_r + 1'b1;
        end
        if (cw.init_en) begin
          started_r <= 1'b1;
        end
      end
    end
  end

  // Datapath, driven by the control word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      price_r <= in_close_price;
      last_r  <= in_is_last;
    end
    if (adv) begin
      if (cw.mul_en) begin
        prod_r <= diff * $signed({1'b0, mul_alpha});
      end
      if (cw.wb_en) begin
        unique case (cw.wb_sel)
          macd_pkg::SEL_SHORT: short_r <= wb_val;
          macd_pkg::SEL_SIG:   sig_r   <= wb_val;
          default:             long_r  <= wb_val;
        endcase
      end
      if (cw.macd_en) begin
        macd_r <= macd_val;
      end
      if (cw.init_en) begin
        long_r  <= $signed({{(AVG_W - macd_pkg::PRICE_W){1'b0}}, price_r});
        short_r <= $signed({{(AVG_W - macd_pkg::PRICE_W){1'b0}}, price_r});
        sig_r   <= '0;
        macd_r  <= '0;
        held_r  <= '0;
        cash_r  <= '0;
      end
      if (cw.trade_en) begin
        if (do_buy) begin
          held_r   <= held_r + 1'b1;
          cash_r   <= macd_pkg::sat_cash(cash_sum);
          action_r <= macd_pkg::ACT_BUY;
        end else if (do_sell) begin
          held_r   <= held_r - 1'b1;
          cash_r   <= macd_pkg::sat_cash(cash_sum);
          action_r <= macd_pkg::ACT_SELL;
        end else begin
          action_r <= macd_pkg::ACT_HOLD;
        end
      end
      if (cw.pmul_en) begin
        pm_r <= held_r * $signed({1'b0, price_r});
      end
      if (cw.done) begin
        out_action_r   <= action_r;
        out_position_r <= held_r;
        out_cash_r     <= cash_r;
        out_profit_r   <= last_r ? macd_pkg::sat_cash(prof_sum) : '0;
        out_last_r     <= last_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_position     = out_position_r;
  assign out_cash         = out_cash_r;
  assign out_final_profit = out_profit_r;
  assign out_last         = out_last_r;

endmodule
